// ----- hdl/dspt_pkg.sv -----
// Package for the 64-bit deterministic strong prime test.
// Holds widths, base and bound tables; no dependencies.
package dspt_pkg;

	localparam int unsigned Width = 64;
	localparam int unsigned NumBases = 12;
	localparam int unsigned BaseIdxW = 4;
	localparam int unsigned BitCntW = 7;

	function automatic logic [5:0] base_of(input logic [BaseIdxW-1:0] idx);
		logic [5:0] b;
		begin
			case (idx)
				4'd0: b = 6'd2;
				4'd1: b = 6'd3;
				4'd2: b = 6'd5;
				4'd3: b = 6'd7;
				4'd4: b = 6'd11;
				4'd5: b = 6'd13;
				4'd6: b = 6'd17;
				4'd7: b = 6'd19;
				4'd8: b = 6'd23;
				4'd9: b = 6'd29;
				4'd10: b = 6'd31;
				default: b = 6'd37;
			endcase
			return b;
		end
	endfunction

	// zero means no bound for that base
	function automatic logic [Width-1:0] bound_of(input logic [BaseIdxW-1:0] idx);
		logic [Width-1:0] v;
		begin
			case (idx)
				4'd0: v = 64'd2047;
				4'd1: v = 64'd1373653;
				4'd2: v = 64'd25326001;
				4'd3: v = 64'd3215031751;
				4'd4: v = 64'd2152302898747;
				4'd5: v = 64'd3474749660383;
				4'd6: v = 64'd341550071728321;
				4'd8: v = 64'd3825123056546413051;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_SETUP  = 10'b0000000010,
		ST_SPLIT  = 10'b0000000100,
		ST_RBEGIN = 10'b0000001000,
		ST_PSTEP  = 10'b0000010000,
		ST_MUL    = 10'b0000100000,
		ST_CHECK  = 10'b0001000000,
		ST_SQLOOP = 10'b0010000000,
		ST_NEXT   = 10'b0100000000,
		ST_DONE   = 10'b1000000000
	} state_t;

	typedef enum logic [1:0] {
		MU_RES = 2'd0,
		MU_SQ  = 2'd1,
		MU_X   = 2'd2
	} mul_op_t;

endpackage

// ----- hdl/deterministic_strong_prime_test_64_top.sv -----
// Deterministic strong prime test for 64-bit candidates.
// start/busy command interface in, one done strobe per item out.
// Depends on dspt_pkg.
//
// Usage: raise start with candidate while busy is low; the item is taken at
// that edge and busy rises. When the test ends, done pulses for one cycle with
// is_prime and witness_base; busy falls in that same cycle, so the next item
// can be taken at the edge that ends it. The receiver cannot stall.
// Flow: trivial cases (below 5 or even) are settled in setup. Otherwise n-1 is split,
// then each base runs at most about 125 modular multiplications for base^d and
// the squarings after it, each one a bit-serial shift-add loop in the one shared
// modular multiplier. A prime above the last bound takes all 12 bases. The
// multiplier loop sets the rate.
// Reset clears the control state; no item is in flight afterwards.
module deterministic_strong_prime_test_64_top #(
	parameter int unsigned W = dspt_pkg::Width
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [W-1:0] candidate,
	output logic         done,
	output logic         is_prime,
	output logic [5:0]   witness_base
);

	dspt_pkg::state_t st_q;
	dspt_pkg::mul_op_t op_q;

	logic [W-1:0] n_q, nm1_q, d_q, e_q, res_q, sq_q, x_q;
	logic [W-1:0] ma_q, mb_q, acc_q;
	logic [dspt_pkg::BitCntW-1:0] cnt_q, s_q, k_q;
	logic [dspt_pkg::BaseIdxW-1:0] bi_q;
	logic prime_q;
	logic [5:0] wit_q;

	// one step of the shift-add modular multiplier: acc = 2acc (+a) mod n
	logic [W:0] dbl, dbl_r, add1;
	logic [W-1:0] acc_d, acc_nx;
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
		acc_d = dbl_r[W-1:0];
		add1 = {1'b0, acc_d} + {1'b0, ma_q};
		if (mb_q[W-1])
			acc_nx = (add1 >= {1'b0, n_q}) ? W'(add1 - {1'b0, n_q}) : add1[W-1:0];
		else
			acc_nx = acc_d;
	end

	logic [W-1:0] base_w;
	assign base_w = W'(dspt_pkg::base_of(bi_q));

	assign busy = (st_q != dspt_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dspt_pkg::ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				dspt_pkg::ST_IDLE: begin
					if (start) begin
						n_q <= candidate;
						st_q <= dspt_pkg::ST_SETUP;
					end
				end
				dspt_pkg::ST_SETUP: begin
					nm1_q <= n_q - W'(1);
					d_q <= n_q - W'(1);
					s_q <= '0;
					cnt_q <= '0;
					bi_q <= '0;
					if (n_q < W'(5)) begin
						prime_q <= (n_q == W'(2)) || (n_q == W'(3));
						wit_q <= '0;
						st_q <= dspt_pkg::ST_DONE;
					end else if (!n_q[0]) begin
						prime_q <= 1'b0;
						wit_q <= 6'd2;
						st_q <= dspt_pkg::ST_DONE;
					end else begin
						st_q <= dspt_pkg::ST_SPLIT;
					end
				end
				dspt_pkg::ST_SPLIT: begin
					// strip one trailing zero per cycle
					if (!d_q[0]) begin
						d_q <= d_q >> 1;
						s_q <= s_q + 1'b1;
					end else begin
						st_q <= dspt_pkg::ST_RBEGIN;
					end
				end
				dspt_pkg::ST_RBEGIN: begin
					res_q <= W'(1);
					sq_q <= (base_w >= n_q) ? base_w - n_q : base_w;
					e_q <= d_q;
					st_q <= dspt_pkg::ST_PSTEP;
				end
				dspt_pkg::ST_PSTEP: begin
					acc_q <= '0;
					cnt_q <= '0;
					if (e_q[0]) begin
						op_q <= dspt_pkg::MU_RES;
						ma_q <= res_q;
						mb_q <= sq_q;
						e_q <= e_q >> 1;
						st_q <= dspt_pkg::ST_MUL;
					end else if (e_q == '0) begin
						x_q <= res_q;
						k_q <= 7'd1;
						st_q <= dspt_pkg::ST_CHECK;
					end else begin
						op_q <= dspt_pkg::MU_SQ;
						ma_q <= sq_q;
						mb_q <= sq_q;
						e_q <= e_q >> 1;
						st_q <= dspt_pkg::ST_MUL;
					end
				end
				dspt_pkg::ST_MUL: begin
					if (cnt_q == 7'(W - 1)) begin
						cnt_q <= '0;
						acc_q <= '0;
						unique case (op_q)
							dspt_pkg::MU_RES: begin
								res_q <= acc_nx;
								// square next unless exponent exhausted
								if (e_q == '0) begin
									x_q <= acc_nx;
									k_q <= 7'd1;
									st_q <= dspt_pkg::ST_CHECK;
								end else begin
									op_q <= dspt_pkg::MU_SQ;
									ma_q <= sq_q;
									mb_q <= sq_q;
								end
							end
							dspt_pkg::MU_SQ: begin
								sq_q <= acc_nx;
								st_q <= dspt_pkg::ST_PSTEP;
							end
							default: begin
								x_q <= acc_nx;
								k_q <= k_q + 1'b1;
								st_q <= dspt_pkg::ST_SQLOOP;
							end
						endcase
					end else begin
						acc_q <= acc_nx;
						mb_q <= mb_q << 1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				dspt_pkg::ST_CHECK: begin
					if (x_q == W'(1) || x_q == nm1_q)
						st_q <= dspt_pkg::ST_NEXT;
					else
						st_q <= dspt_pkg::ST_SQLOOP;
				end
				dspt_pkg::ST_SQLOOP: begin
					if (op_q == dspt_pkg::MU_X && x_q == nm1_q && k_q != 7'd1) begin
						st_q <= dspt_pkg::ST_NEXT;
					end else if (k_q < s_q) begin
						op_q <= dspt_pkg::MU_X;
						ma_q <= x_q;
						mb_q <= x_q;
						acc_q <= '0;
						cnt_q <= '0;
						st_q <= dspt_pkg::ST_MUL;
					end else begin
						prime_q <= 1'b0;
						wit_q <= dspt_pkg::base_of(bi_q);
						st_q <= dspt_pkg::ST_DONE;
					end
				end
				dspt_pkg::ST_NEXT: begin
					op_q <= dspt_pkg::MU_RES;
					if ((n_q < dspt_pkg::bound_of(bi_q)) ||
					    (bi_q == 4'(dspt_pkg::NumBases - 1))) begin
						prime_q <= 1'b1;
						wit_q <= '0;
						st_q <= dspt_pkg::ST_DONE;
					end else begin
						bi_q <= bi_q + 1'b1;
						st_q <= dspt_pkg::ST_RBEGIN;
					end
				end
				dspt_pkg::ST_DONE: begin
					is_prime <= prime_q;
					witness_base <= wit_q;
					done <= 1'b1;
					st_q <= dspt_pkg::ST_IDLE;
				end
				default: st_q <= dspt_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/dspt_checker.sv -----
// Port-level checker for the strong prime test, bound to the top level.
// Depends on deterministic_strong_prime_test_64_top ports only.
module dspt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       is_prime,
	input logic [5:0] witness_base
);

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("item taken but busy low");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	a_prime_wit: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_prime |-> witness_base == 6'd0) else $error("prime with witness");

	a_wit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> witness_base <= 6'd37) else $error("witness out of range");

endmodule

bind deterministic_strong_prime_test_64_top dspt_checker u_dspt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.is_prime(is_prime), .witness_base(witness_base)
);
